### rtl/sjt_pkg.sv
package sjt_pkg;

	localparam int DIV_STEPS = 62;
	localparam int XY_W = 34;
	localparam int Z_W = 35;

	localparam logic [33:0] TWO_PI_U = 34'd6746518852;
	localparam logic signed [Z_W-1:0] TWO_PI_Q30 = 35'sd6746518852;
	localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [XY_W-1:0] ONE_Q30 = 34'sd1073741824;
	localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0] LEAD_RESET = 32'd65536;

	function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'd843314857;
			5'd1: v = 32'd497837829;
			5'd2: v = 32'd263043837;
			5'd3: v = 32'd133525159;
			5'd4: v = 32'd67021687;
			5'd5: v = 32'd33543516;
			5'd6: v = 32'd16775851;
			5'd7: v = 32'd8388437;
			5'd8: v = 32'd4194283;
			5'd9: v = 32'd2097149;
			5'd31: v = 32'd0;
			default: v = 32'd1 << (5'd30 - idx);
		endcase
		return $signed({3'b000, v});
	endfunction

endpackage

### rtl/screw_joint_transform.sv
// Channel   | Handshake              | Payload
// in        | in_valid / in_ready    | displacement
// out       | out_valid / out_ready  | cos_angle, sin_angle, translation_z, lead_zero_error
// cfg       | cfg_valid / cfg_ready  | screw_lead
//
// One item enters every cycle while the output is not stalled. The pipeline is the input
// register, the 62 one-bit divide/modulo steps, two angle fold stages, one stage per
// CORDIC rotation and the output register. Reset clears all valid bits and sets the
// lead to 1.0.
// When the output item is not taken, the whole pipeline holds in place.
module screw_joint_transform #(
	parameter int CORDIC_STAGES = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] displacement,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] cos_angle,
	output logic signed [31:0] sin_angle,
	output logic signed [31:0] translation_z,
	output logic               lead_zero_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic signed [31:0] screw_lead
);

	localparam int ND = sjt_pkg::DIV_STEPS;
	localparam int XW = sjt_pkg::XY_W;
	localparam int ZW = sjt_pkg::Z_W;

	logic        en;
	logic [31:0] lead_q;

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= sjt_pkg::LEAD_RESET;
		end else if (cfg_valid) begin
			lead_q <= screw_lead;
		end
	end

	// Stage 1: magnitudes and sign of the quotient.
	logic               valid_s1;
	logic signed [31:0] d_s1;
	logic [31:0]        nd_s1, nl_s1;
	logic               neg_s1, err_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= displacement;
			nd_s1 <= displacement[31] ? 32'(-displacement) : displacement;
			nl_s1 <= lead_q[31] ? 32'(-lead_q) : lead_q;
			neg_s1 <= displacement[31] != lead_q[31];
			err_s1 <= lead_q == 32'd0;
		end
	end

	// Division steps: each produces one quotient bit and folds it straight into
	// the running remainder modulo two pi, so the wide quotient is never stored.
	logic               dv_v_s [ND];
	logic [31:0]        dv_rem_s [ND];
	logic [32:0]        dv_mod_s [ND];
	logic [31:0]        dv_num_s [ND];
	logic [31:0]        dv_nl_s [ND];
	logic               dv_neg_s [ND];
	logic               dv_err_s [ND];
	logic signed [31:0] dv_d_s [ND];

	for (genvar k = 0; k < ND; k++) begin : g_div
		logic               v_in, neg_in, err_in, nbit, ge, mge;
		logic [31:0]        rem_in, num_in, nl_in;
		logic [32:0]        mod_in, rsh;
		logic [33:0]        msh;
		logic signed [31:0] d_in;

		if (k == 0) begin : g_first
			assign v_in = valid_s1;
			assign rem_in = '0;
			assign mod_in = '0;
			assign num_in = nd_s1;
			assign nl_in = nl_s1;
			assign neg_in = neg_s1;
			assign err_in = err_s1;
			assign d_in = d_s1;
		end else begin : g_next
			assign v_in = dv_v_s[k-1];
			assign rem_in = dv_rem_s[k-1];
			assign mod_in = dv_mod_s[k-1];
			assign num_in = dv_num_s[k-1];
			assign nl_in = dv_nl_s[k-1];
			assign neg_in = dv_neg_s[k-1];
			assign err_in = dv_err_s[k-1];
			assign d_in = dv_d_s[k-1];
		end

		if (k < 32) begin : g_nb
			assign nbit = num_in[31-k];
		end else begin : g_zb
			assign nbit = 1'b0;
		end

		assign rsh = {rem_in, nbit};
		assign ge = rsh >= {1'b0, nl_in};
		assign msh = {mod_in, ge};
		assign mge = msh >= sjt_pkg::TWO_PI_U;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (en) begin
				dv_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[k] <= ge ? 32'(rsh - {1'b0, nl_in}) : rsh[31:0];
				dv_mod_s[k] <= mge ? 33'(msh - sjt_pkg::TWO_PI_U) : msh[32:0];
				dv_num_s[k] <= num_in;
				dv_nl_s[k] <= nl_in;
				dv_neg_s[k] <= neg_in;
				dv_err_s[k] <= err_in;
				dv_d_s[k] <= d_in;
			end
		end
	end

	// Stage 2: apply sign and bring the angle into (-pi, pi].
	logic               valid_s2, err_s2;
	logic signed [ZW-1:0] a_s2;
	logic signed [31:0] d_s2;
	logic [32:0]        radj;
	logic signed [ZW-1:0] aw;

	always_comb begin
		radj = (dv_neg_s[ND-1] && dv_mod_s[ND-1] != 33'd0) ?
			33'(sjt_pkg::TWO_PI_U - {1'b0, dv_mod_s[ND-1]}) : dv_mod_s[ND-1];
		aw = $signed({2'b00, radj});
		if (aw > sjt_pkg::PI_Q30) begin
			aw = aw - sjt_pkg::TWO_PI_Q30;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= dv_v_s[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= aw;
			err_s2 <= dv_err_s[ND-1];
			d_s2 <= dv_d_s[ND-1];
		end
	end

	// Stage 3: fold into [-pi/2, pi/2]; a fold negates both outputs.
	logic               valid_s3, err_s3, flip_s3;
	logic signed [ZW-1:0] z_s3;
	logic signed [31:0] d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s3 <= err_s2;
			d_s3 <= d_s2;
			if (a_s2 > sjt_pkg::HALF_PI_Q30) begin
				z_s3 <= a_s2 - sjt_pkg::PI_Q30;
				flip_s3 <= 1'b1;
			end else if (a_s2 < -sjt_pkg::HALF_PI_Q30) begin
				z_s3 <= a_s2 + sjt_pkg::PI_Q30;
				flip_s3 <= 1'b1;
			end else begin
				z_s3 <= a_s2;
				flip_s3 <= 1'b0;
			end
		end
	end

	// CORDIC rotation stages.
	logic                 cr_v_s [CORDIC_STAGES];
	logic signed [XW-1:0] cr_x_s [CORDIC_STAGES];
	logic signed [XW-1:0] cr_y_s [CORDIC_STAGES];
	logic signed [ZW-1:0] cr_z_s [CORDIC_STAGES];
	logic                 cr_err_s [CORDIC_STAGES];
	logic                 cr_flip_s [CORDIC_STAGES];
	logic signed [31:0]   cr_d_s [CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		logic                 v_in, err_in, flip_in;
		logic signed [XW-1:0] x_in, y_in, dx, dy;
		logic signed [ZW-1:0] z_in, at;
		logic signed [31:0]   d_in;

		if (i == 0) begin : g_first
			assign v_in = valid_s3;
			assign x_in = sjt_pkg::GAIN_Q30;
			assign y_in = '0;
			assign z_in = z_s3;
			assign err_in = err_s3;
			assign flip_in = flip_s3;
			assign d_in = d_s3;
		end else begin : g_next
			assign v_in = cr_v_s[i-1];
			assign x_in = cr_x_s[i-1];
			assign y_in = cr_y_s[i-1];
			assign z_in = cr_z_s[i-1];
			assign err_in = cr_err_s[i-1];
			assign flip_in = cr_flip_s[i-1];
			assign d_in = cr_d_s[i-1];
		end

		assign dx = y_in >>> i;
		assign dy = x_in >>> i;
		assign at = sjt_pkg::atan_q30(5'(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_v_s[i] <= 1'b0;
			end else if (en) begin
				cr_v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_in[ZW-1]) begin
					cr_x_s[i] <= x_in - dx;
					cr_y_s[i] <= y_in + dy;
					cr_z_s[i] <= z_in - at;
				end else begin
					cr_x_s[i] <= x_in + dx;
					cr_y_s[i] <= y_in - dy;
					cr_z_s[i] <= z_in + at;
				end
				cr_err_s[i] <= err_in;
				cr_flip_s[i] <= flip_in;
				cr_d_s[i] <= d_in;
			end
		end
	end

	// Output register: saturate, undo the fold, force zero on a zero lead.
	logic signed [XW-1:0] xc, yc, xo, yo;

	always_comb begin
		xc = cr_x_s[CORDIC_STAGES-1];
		yc = cr_y_s[CORDIC_STAGES-1];
		if (xc > sjt_pkg::ONE_Q30) xc = sjt_pkg::ONE_Q30;
		if (xc < -sjt_pkg::ONE_Q30) xc = -sjt_pkg::ONE_Q30;
		if (yc > sjt_pkg::ONE_Q30) yc = sjt_pkg::ONE_Q30;
		if (yc < -sjt_pkg::ONE_Q30) yc = -sjt_pkg::ONE_Q30;
		xo = cr_flip_s[CORDIC_STAGES-1] ? -xc : xc;
		yo = cr_flip_s[CORDIC_STAGES-1] ? -yc : yc;
		if (cr_err_s[CORDIC_STAGES-1]) begin
			xo = '0;
			yo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= cr_v_s[CORDIC_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_angle <= xo[31:0];
			sin_angle <= yo[31:0];
			translation_z <= cr_d_s[CORDIC_STAGES-1];
			lead_zero_error <= cr_err_s[CORDIC_STAGES-1];
		end
	end

endmodule

### sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = 30;
	localparam int LATENCY = 66 + STAGES;
	localparam longint TWO_PI = 64'sd6746518852;
	localparam longint PI = 64'sd3373259426;
	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint UNIT = 64'sd1073741824;
	localparam longint GAIN = 64'sd652032874;

	typedef struct packed {
		logic [31:0] cos_v;
		logic [31:0] sin_v;
		logic [31:0] trans_v;
		logic err_v;
	} pose_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [31:0] displacement = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] cos_angle, sin_angle, translation_z;
	logic lead_zero_error;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic signed [31:0] screw_lead = '0;

	pose_t pending_poses[$];
	logic signed [31:0] lead_now = 32'sd65536;
	int mismatches = 0;
	int received = 0;
	int sent = 0;
	int zero_lead_items = 0;
	bit rx_stall_enable = 1;

	screw_joint_transform #(.CORDIC_STAGES(STAGES)) dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint arctan_step(int i);
		if (i < 10) begin
			case (i)
				0: return 843314857;
				1: return 497837829;
				2: return 263043837;
				3: return 133525159;
				4: return 67021687;
				5: return 33543516;
				6: return 16775851;
				7: return 8388437;
				8: return 4194283;
				default: return 2097149;
			endcase
		end
		if (i >= 31) return 0;
		return 64'sd1 << (30 - i);
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > UNIT) return UNIT;
		if (v < -UNIT) return -UNIT;
		return v;
	endfunction

	function automatic pose_t screw_pose(logic signed [31:0] disp, logic signed [31:0] lead);
		pose_t p;
		longint d, l, a, x, y, z, dx, dy;
		longint unsigned nd, nl, q, r;
		bit flip;
		d = disp;
		l = lead;
		p.trans_v = disp;
		p.err_v = (l == 0);
		p.cos_v = '0;
		p.sin_v = '0;
		if (l != 0) begin
			nd = d < 0 ? -d : d;
			nl = l < 0 ? -l : l;
			q = (nd << 30) / nl;
			r = q % TWO_PI;
			if (((d < 0) != (l < 0)) && r != 0) r = TWO_PI - r;
			a = r;
			flip = 0;
			if (a > PI) a -= TWO_PI;
			if (a > HALF_PI) begin
				a -= PI;
				flip = 1;
			end else if (a < -HALF_PI) begin
				a += PI;
				flip = 1;
			end
			x = GAIN;
			y = 0;
			z = a;
			for (int i = 0; i < STAGES && i < 32; i++) begin
				dx = asr(y, i);
				dy = asr(x, i);
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= arctan_step(i);
				end else begin
					x += dx;
					y -= dy;
					z += arctan_step(i);
				end
			end
			x = clamp_unit(x);
			y = clamp_unit(y);
			if (flip) begin
				x = -x;
				y = -y;
			end
			p.cos_v = x[31:0];
			p.sin_v = y[31:0];
		end
		return p;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// Receiver side: random stalls while rx_stall_enable is set, checks each item against the oldest expectation.
	always @(posedge clk) begin
		pose_t want, got;
		if (out_valid && out_ready) begin
			got = '{cos_angle, sin_angle, translation_z, lead_zero_error};
			received++;
			if (pending_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output item %h", got);
			end else begin
				want = pending_poses.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: cos %h/%h sin %h/%h z %h/%h err %b/%b",
							want.cos_v, got.cos_v, want.sin_v, got.sin_v,
							want.trans_v, got.trans_v, want.err_v, got.err_v);
				end
			end
		end
	end

	initial begin
		int g;
		forever begin
			@(negedge clk);
			if (!rx_stall_enable) out_ready <= 1;
			else begin
				g = gap_len();
				if (g == 0) out_ready <= 1;
				else begin
					out_ready <= 0;
					repeat (g) @(negedge clk);
					out_ready <= 1;
				end
			end
		end
	end

	// Valid stays high after an item is taken; it drops only when a gap follows or the bench drains.
	task automatic send_disp(logic signed [31:0] d, bit no_gap = 0);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		displacement <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_poses.push_back(screw_pose(d, lead_now));
		if (lead_now == 0) zero_lead_items++;
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_lead(logic signed [31:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1;
		screw_lead <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		lead_now = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic test_reset_lead();
		send_disp(32'sd0);
		send_disp(32'sd102944);
		send_disp(32'sd205887);
		send_disp(-32'sd102944);
		send_disp(32'sh7fffffff);
		send_disp(32'sh80000000);
		send_disp(32'sd1);
		send_disp(-32'sd1);
	endtask

	task automatic test_lead_extremes();
		write_lead(32'sh7fffffff);
		send_disp(32'sh7fffffff);
		send_disp(32'sh80000000);
		write_lead(32'sh80000000);
		send_disp(32'sh80000000);
		send_disp(32'sh7fffffff);
		send_disp(32'sd12345);
		write_lead(32'sd1);
		send_disp(32'sh7fffffff);
		send_disp(32'sh80000000);
		write_lead(-32'sd1);
		send_disp(32'sd77777);
		send_disp(-32'sd3);
	endtask

	task automatic test_zero_lead();
		write_lead(32'sd0);
		send_disp(32'sd0);
		send_disp(32'sh7fffffff);
		send_disp(32'sh80000000);
	endtask

	task automatic test_random_leads();
		logic signed [31:0] d;
		for (int phase = 0; phase < 10; phase++) begin
			case ($urandom_range(0, 4))
				0: write_lead($urandom);
				1: write_lead($urandom_range(1, 1 << 20));
				2: write_lead(-$signed($urandom_range(1, 1 << 20)));
				3: write_lead(phase == 3 ? 32'sd0 : 32'sd65536);
				default: write_lead($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
			endcase
			rx_stall_enable = (phase % 4 != 1);
			for (int k = 0; k < 115; k++) begin
				case ($urandom_range(0, 3))
					0: d = $urandom;
					1: d = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
					2: d = $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 9)
						: 32'sh80000000 + $urandom_range(0, 9);
					default: d = $urandom;
				endcase
				send_disp(d, phase % 4 == 1);
			end
		end
		rx_stall_enable = 1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		test_reset_lead();
		test_lead_extremes();
		test_zero_lead();
		test_random_leads();
		drain();
		$display("Sent %0d displacements, %0d with a zero lead; %0d poses checked.",
			sent, zero_lead_items, received);
		if (mismatches == 0 && pending_poses.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d missing", mismatches, pending_poses.size());
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
